@@ rtl/core/bdp_pkg.sv @@
// Package for the binomial divisibility block: widths, stream layout, FSM states.
// No dependencies.
package bdp_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int PRIME_WIDTH = 16;
  localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
  localparam int IN_TDATA_W  = ((2 * VALUE_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 8;

  localparam logic [PRIME_WIDTH-1:0] BASE_MIN = PRIME_WIDTH'(2);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIGIT,
    ST_DIV,
    ST_EMIT
  } bdp_state_e;

endpackage

@@ rtl/core/binomial_divisibility_by_prime.sv @@
// Lucas-test top level: bit-serial base-p digit split of two values, digit compare.
// Depends on bdp_pkg.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_axis_tvalid/tready    tdata: upper_value, lower_value
//  m_axis    out  m_axis_tvalid/tready    tdata: divides_flag, digitwise_leq_flag
//  cfg       in   cfg_we_i                cfg_wdata_i: prime_base
//
// Each digit comes from the restoring divider (one quotient bit per cycle, both values
// in parallel) followed by a compare step; an item ends early when the values run out
// of digits or a digit exceeds. One item is in work at a time.
// Reset brings prime_base to 2 and empties the output register.
// The output register holds a result under stall while the next item is taken.
module binomial_divisibility_by_prime (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [bdp_pkg::PRIME_WIDTH-1:0]  cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [VALUE_WIDTH-1:0] upper_value, [2*VALUE_WIDTH-1:VALUE_WIDTH] lower_value
  input  logic [bdp_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] divides_flag, [1] digitwise_leq_flag, rest zero
  output logic [bdp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import bdp_pkg::*;

  bdp_state_e             state_q, state_d;
  logic [PRIME_WIDTH-1:0] base_q;
  logic [VALUE_WIDTH-1:0] hi_q, hi_d, lo_q, lo_d;
  logic [PRIME_WIDTH-1:0] rhi_q, rhi_d, rlo_q, rlo_d;
  logic [CNT_WIDTH-1:0]   cnt_q, cnt_d;
  logic                   hit_q, hit_d;
  logic                   mvalid_q, mvalid_d;
  logic                   mhit_q, mhit_d;

  logic [PRIME_WIDTH:0]   hi_trial, lo_trial, base_ext;
  logic                   hi_ge, lo_ge;

  // config register, base below two acts as two
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= BASE_MIN;
    end else if (cfg_we_i) begin
      base_q <= (cfg_wdata_i < BASE_MIN) ? BASE_MIN : cfg_wdata_i;
    end
  end

  // one restoring-division step per value
  assign base_ext = {1'b0, base_q};
  assign hi_trial = {rhi_q, hi_q[VALUE_WIDTH-1]};
  assign lo_trial = {rlo_q, lo_q[VALUE_WIDTH-1]};
  assign hi_ge    = hi_trial >= base_ext;
  assign lo_ge    = lo_trial >= base_ext;

  always_comb begin
    state_d  = state_q;
    hi_d     = hi_q;
    lo_d     = lo_q;
    rhi_d    = rhi_q;
    rlo_d    = rlo_q;
    cnt_d    = cnt_q;
    hit_d    = hit_q;
    mvalid_d = mvalid_q && !m_axis_tready;
    mhit_d   = mhit_q;
    s_axis_tready = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          hi_d    = s_axis_tdata[VALUE_WIDTH-1:0];
          lo_d    = s_axis_tdata[2*VALUE_WIDTH-1:VALUE_WIDTH];
          rhi_d   = '0;
          rlo_d   = '0;
          hit_d   = 1'b0;
          state_d = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (rlo_q > rhi_q) begin
          hit_d   = 1'b1;
          state_d = ST_EMIT;
        end else if (hi_q == '0 && lo_q == '0) begin
          state_d = ST_EMIT;
        end else begin
          rhi_d   = '0;
          rlo_d   = '0;
          cnt_d   = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        rhi_d = hi_ge ? PRIME_WIDTH'(hi_trial - base_ext) : hi_trial[PRIME_WIDTH-1:0];
        rlo_d = lo_ge ? PRIME_WIDTH'(lo_trial - base_ext) : lo_trial[PRIME_WIDTH-1:0];
        hi_d  = {hi_q[VALUE_WIDTH-2:0], hi_ge};
        lo_d  = {lo_q[VALUE_WIDTH-2:0], lo_ge};
        cnt_d = cnt_q + CNT_WIDTH'(1);
        if (cnt_q == CNT_WIDTH'(VALUE_WIDTH - 1)) begin
          state_d = ST_DIGIT;
        end
      end
      ST_EMIT: begin
        if (!mvalid_q || m_axis_tready) begin
          mvalid_d = 1'b1;
          mhit_d   = hit_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mvalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      mvalid_q <= mvalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hi_q   <= hi_d;
    lo_q   <= lo_d;
    rhi_q  <= rhi_d;
    rlo_q  <= rlo_d;
    cnt_q  <= cnt_d;
    hit_q  <= hit_d;
    mhit_q <= mhit_d;
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - 2){1'b0}}, !mhit_q, mhit_q};

endmodule

@@ rtl/core/bdp_checker.sv @@
// Port-level checks for binomial_divisibility_by_prime, bound to the top level.
// Depends on bdp_pkg.
module bdp_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [bdp_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
  import bdp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped under stall");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed under stall");

  a_flags_compl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] != m_axis_tdata[1])
    else $error("flags not complementary");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:2] == '0)
    else $error("padding bits not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("ready while a transaction is in work");

endmodule

bind binomial_divisibility_by_prime bdp_checker u_bdp_checker (.*);

@@ tb/sv/binomial_divisibility_by_prime_test.sv @@
// Self-checking bench for binomial_divisibility_by_prime: base-p digit compare
// (Lucas test) of two streamed values, checked against a scoreboard model.
// Depends on bdp_pkg and the binomial_divisibility_by_prime RTL.
module binomial_divisibility_by_prime_test;
  import bdp_pkg::*;

  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [VALUE_WIDTH-1:0] ALL_ONES = '1;

  class lucas_flag_board;
    typedef struct packed {
      logic divides;
      logic leq;
    } flag_pair_t;

    flag_pair_t             awaited_flags[$];
    logic [PRIME_WIDTH-1:0] prime_reg;
    int                     failures;

    function new();
      prime_reg = BASE_MIN;
      failures  = 0;
    endfunction

    function void load_prime(logic [PRIME_WIDTH-1:0] value);
      prime_reg = value;
    endfunction

    // bases 0 and 1 fall back to 2
    function logic [VALUE_WIDTH-1:0] radix();
      return (prime_reg < BASE_MIN) ? VALUE_WIDTH'(BASE_MIN) : VALUE_WIDTH'(prime_reg);
    endfunction

    function bit lucas_exceeds(logic [VALUE_WIDTH-1:0] upper, logic [VALUE_WIDTH-1:0] lower);
      logic [VALUE_WIDTH-1:0] p;
      int n;
      p = radix();
      for (n = 0; n < VALUE_WIDTH && (upper != 0 || lower != 0); n++) begin
        if (lower % p > upper % p) return 1'b1;
        upper = upper / p;
        lower = lower / p;
      end
      return 1'b0;
    endfunction

    function void note_operands(logic [VALUE_WIDTH-1:0] upper, logic [VALUE_WIDTH-1:0] lower);
      bit hit;
      flag_pair_t entry;
      hit           = lucas_exceeds(upper, lower);
      entry.divides = hit;
      entry.leq     = !hit;
      awaited_flags = {awaited_flags, entry};
    endfunction

    function void check_flags(logic [OUT_TDATA_W-1:0] beat);
      flag_pair_t want;
      if (awaited_flags.size() == 0) begin
        $error("result transaction with nothing awaited: tdata %0h", beat);
        failures++;
        return;
      end
      want = awaited_flags.pop_front();
      if (beat[0] !== want.divides) begin
        $error("divides_flag: expected %0b, got %0b", want.divides, beat[0]);
        failures++;
      end
      if (beat[1] !== want.leq) begin
        $error("digitwise_leq_flag: expected %0b, got %0b", want.leq, beat[1]);
        failures++;
      end
      if (beat[OUT_TDATA_W-1:2] !== '0) begin
        $error("padding: expected 0, got %0h", beat[OUT_TDATA_W-1:2]);
        failures++;
      end
    endfunction

    function int pending();
      return awaited_flags.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [PRIME_WIDTH-1:0] cfg_wdata_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;  // [63:0] upper_value, [127:64] lower_value
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;  // [0] divides_flag, [1] digitwise_leq_flag, pad

  lucas_flag_board board = new();
  int send_idle_pct = 23;
  int recv_idle_pct = 80;
  int cycle_count   = 0;

  binomial_divisibility_by_prime dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("binomial_divisibility_by_prime verification failed");
    $finish;
  end

  // result side: random back-pressure, check every accepted transaction
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) board.check_flags(m_axis_tdata);
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [VALUE_WIDTH-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  task automatic send_operands(logic [VALUE_WIDTH-1:0] upper, logic [VALUE_WIDTH-1:0] lower);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {lower, upper};
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_operands(upper, lower);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_prime(logic [PRIME_WIDTH-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    board.load_prime(value);
  endtask

  // Mostly digit-wise well-formed pairs, some with one digit pushed over,
  // the rest plain noise and short values.
  task automatic make_operands(output logic [VALUE_WIDTH-1:0] upper,
                               output logic [VALUE_WIDTH-1:0] lower);
    logic [VALUE_WIDTH-1:0] p, rest, weight, digit, low_digit;
    int kind, width, ndig, bump_at, n;
    p     = board.radix();
    kind  = $urandom_range(99);
    width = ($urandom_range(3) == 0) ? VALUE_WIDTH : $urandom_range(1, 20);
    upper = random_word() >> (VALUE_WIDTH - width);
    lower = '0;
    if (kind < 70) begin
      rest = upper;
      ndig = 0;
      while (rest != 0) begin
        rest = rest / p;
        ndig++;
      end
      bump_at = (kind >= 50 && ndig > 0) ? $urandom_range(0, ndig - 1) : -1;
      rest    = upper;
      weight  = 1;
      for (n = 0; n < ndig; n++) begin
        digit = rest % p;
        rest  = rest / p;
        if (n == bump_at && digit < p - 1)
          low_digit = digit + 1 + random_word() % (p - 1 - digit);
        else
          low_digit = random_word() % (digit + 1);
        lower  = lower + low_digit * weight;
        weight = weight * p;
      end
    end else if (kind < 85) begin
      upper = random_word();
      lower = random_word();
    end else begin
      lower = random_word() >> (VALUE_WIDTH - $urandom_range(1, 20));
    end
  endtask

  task automatic run_phase(logic [PRIME_WIDTH-1:0] prime, int sender_idle, int receiver_idle,
                           int count);
    logic [VALUE_WIDTH-1:0] upper, lower;
    drain_results();
    load_prime(prime);
    send_idle_pct = sender_idle;
    recv_idle_pct = receiver_idle;
    repeat (count) begin
      make_operands(upper, lower);
      send_operands(upper, lower);
    end
  endtask

  initial begin
    logic [VALUE_WIDTH-1:0] same;
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at the reset base of 2
    same = random_word();
    send_operands('0, '0);
    send_operands(ALL_ONES, ALL_ONES);
    send_operands(ALL_ONES, '0);
    send_operands('0, ALL_ONES);
    send_operands(64'd1, 64'd2);
    send_operands(64'd2, 64'd1);
    send_operands(64'd5, 64'd3);
    send_operands(64'd7, 64'd3);
    send_operands(64'd6, 64'd3);
    send_operands(ALL_ONES - 1, 64'd1);
    send_operands(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    send_operands(64'h8000_0000_0000_0000, 64'd1);
    send_operands(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_operands(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
    send_operands(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_operands(same, same);
    send_operands(same, same & 64'h0F0F_0F0F_0F0F_0F0F);

    run_phase(16'd0,     23, 80, 15);
    run_phase(16'd1,     23, 80, 10);
    run_phase(16'd3,     23, 80, 20);
    run_phase(16'd65535, 80, 23, 20);
    run_phase(16'd65521, 80, 23, 10);
    run_phase(16'd7,     80, 23, 20);
    run_phase(16'd2,      0,  0, 15);
    run_phase(16'd257,    0,  0, 15);

    drain_results();
    repeat (4 * SETTLE_CYCLES) @(posedge clk_i);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("binomial_divisibility_by_prime verification clean");
    end else begin
      $display("binomial_divisibility_by_prime verification failed");
    end
    $finish;
  end

endmodule
